### design/bgr_to_hsv_pixel_top_assert.svh
// Assertion macros shared by the pixel converter RTL.
`ifndef BGR_TO_HSV_PIXEL_TOP_ASSERT_SVH
`define BGR_TO_HSV_PIXEL_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Property checked only outside reset.
`define B2H_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked on every edge, reset included.
`define B2H_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define B2H_ASSERT(lbl, prop, msg)
`define B2H_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### design/b2h_pkg.sv
// Shared types for the BGR to HSV pixel converter.
`timescale 1ns / 1ps
`default_nettype none
package b2h_pkg;

  // Divider layout: stages times quotient bits per stage gives the 8-bit quotient
  localparam int NumDivStages    = 4;
  localparam int DivBitsPerStage = 2;

  // Channel that holds the maximum (ties: red, then green)
  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } sel_t;

  // One divider pipeline slot: two restoring divisions side by side.
  // *_low starts as the low numerator byte and ends as the quotient.
  typedef struct packed {
    logic       valid;
    logic [8:0] hue_rem;
    logic [8:0] hue_den;
    logic [7:0] hue_low;
    logic [7:0] sat_rem;
    logic [7:0] sat_den;
    logic [7:0] sat_low;
    logic [7:0] bright;
  } div_t;

endpackage
`default_nettype wire

### design/b2h_div_step.sv
// One registered stage of the divider: two quotient bits for hue and saturation.
`timescale 1ns / 1ps
`default_nettype none
`include "bgr_to_hsv_pixel_top_assert.svh"
module b2h_div_step (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire b2h_pkg::div_t d,
  output b2h_pkg::div_t      q
);
  import b2h_pkg::*;

  div_t nxt;

  // Two restoring steps: shift in a numerator bit, subtract when it fits
  always_comb begin
    logic [9:0] ht;
    logic [8:0] st;
    nxt = d;
    for (int i = 0; i < DivBitsPerStage; i++) begin
      ht = {nxt.hue_rem, nxt.hue_low[7]};
      if (ht >= {1'b0, nxt.hue_den}) begin
        nxt.hue_rem = 9'(ht - {1'b0, nxt.hue_den});
        nxt.hue_low = {nxt.hue_low[6:0], 1'b1};
      end else begin
        nxt.hue_rem = ht[8:0];
        nxt.hue_low = {nxt.hue_low[6:0], 1'b0};
      end
      st = {nxt.sat_rem, nxt.sat_low[7]};
      if (st >= {1'b0, nxt.sat_den}) begin
        nxt.sat_rem = 8'(st - {1'b0, nxt.sat_den});
        nxt.sat_low = {nxt.sat_low[6:0], 1'b1};
      end else begin
        nxt.sat_rem = st[7:0];
        nxt.sat_low = {nxt.sat_low[6:0], 1'b0};
      end
    end
  end

  // Stage register; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= nxt;
    end
  end

  // Partial remainders stay below their divisors
  `B2H_ASSERT(a_hue_rem, q.valid |-> (q.hue_rem < q.hue_den), "hue remainder not below divisor")
  `B2H_ASSERT(a_sat_rem, q.valid |-> (q.sat_rem < q.sat_den), "sat remainder not below divisor")
  `B2H_ASSERT(a_den_nz, q.valid |-> (q.hue_den != 9'd0 && q.sat_den != 8'd0),
              "zero divisor in pipeline")

endmodule
`default_nettype wire

### design/bgr_to_hsv_pixel_top.sv
// Top level of the BGR to HSV pixel converter.
`timescale 1ns / 1ps
`default_nettype none
`include "bgr_to_hsv_pixel_top_assert.svh"
// Converts one 8-bit BGR pixel per clock to hue (half degrees, 0..179),
// saturation and value. The pipeline is six register stages deep: min/max
// and channel select, numerator build, then four divider stages that each
// resolve two quotient bits of both the hue and the saturation division.
// A request is taken every cycle while the output is not held. When the
// output is held, the whole pipeline stalls and s_tready drops. A grey
// pixel (all channels equal) gives hue 0 and saturation 0.
module bgr_to_hsv_pixel_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // blue[7:0], green[15:8], red[23:16]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // hue_half_deg[7:0], saturation[15:8], brightness[23:16]
);
  import b2h_pkg::*;

  logic en;
  logic [7:0] in_b, in_g, in_r;

  // Stage 1 registers
  logic       s1_valid;
  logic [7:0] s1_max;
  logic [7:0] s1_chroma;
  sel_t       s1_sel;
  logic [8:0] s1_diff;

  logic [7:0] a_max, a_min;
  sel_t       a_sel;
  logic [8:0] a_diff;

  div_t div_in;
  div_t div_s2;
  div_t div_q [NumDivStages+1];

  // Global advance: move when the output slot is free or being taken
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign in_b = s_tdata[7:0];
  assign in_g = s_tdata[15:8];
  assign in_r = s_tdata[23:16];

  // Max, min, winning channel and its signed difference
  always_comb begin
    a_max = (in_r >= in_g) ? in_r : in_g;
    if (in_b > a_max) a_max = in_b;
    a_min = (in_r <= in_g) ? in_r : in_g;
    if (in_b < a_min) a_min = in_b;
    if (a_max == in_r) begin
      a_sel  = SEL_RED;
      a_diff = {1'b0, in_g} - {1'b0, in_b};
    end else if (a_max == in_g) begin
      a_sel  = SEL_GREEN;
      a_diff = {1'b0, in_b} - {1'b0, in_r};
    end else begin
      a_sel  = SEL_BLUE;
      a_diff = {1'b0, in_r} - {1'b0, in_g};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= s_tvalid;
      s1_max    <= a_max;
      s1_chroma <= a_max - a_min;
      s1_sel    <= a_sel;
      s1_diff   <= a_diff;
    end
  end

  // Numerators and divisors; grey pixels divide zero by one
  always_comb begin
    logic signed [18:0] c_s, d_s, h_num;
    logic        [16:0] h_u;
    logic        [15:0] s_num;
    c_s = signed'({11'd0, s1_chroma});
    d_s = signed'({{10{s1_diff[8]}}, s1_diff});
    h_num = d_s * 19'sd60;
    case (s1_sel)
      SEL_GREEN: h_num = h_num + c_s * 19'sd120;
      SEL_BLUE:  h_num = h_num + c_s * 19'sd240;
      default:   h_num = h_num;
    endcase
    if (h_num < 0) h_num = h_num + c_s * 19'sd360;
    h_u   = h_num[16:0];
    s_num = {s1_chroma, 8'd0} - {8'd0, s1_chroma};

    div_in.valid  = s1_valid;
    div_in.bright = s1_max;
    if (s1_chroma == 8'd0) begin
      div_in.hue_rem = 9'd0;
      div_in.hue_low = 8'd0;
      div_in.hue_den = 9'd1;
      div_in.sat_rem = 8'd0;
      div_in.sat_low = 8'd0;
      div_in.sat_den = 8'd1;
    end else begin
      div_in.hue_rem = h_u[16:8];
      div_in.hue_low = h_u[7:0];
      div_in.hue_den = {s1_chroma, 1'b0};
      div_in.sat_rem = s_num[15:8];
      div_in.sat_low = s_num[7:0];
      div_in.sat_den = s1_max;
    end
  end

  // Stage 2 register: divider input
  always_ff @(posedge clk) begin
    if (rst) begin
      div_s2.valid <= 1'b0;
    end else if (en) begin
      div_s2 <= div_in;
    end
  end

  assign div_q[0] = div_s2;

  // Divider stages
  for (genvar k = 0; k < NumDivStages; k++) begin : g_div
    b2h_div_step u_step (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (div_q[k]),
      .q   (div_q[k+1])
    );
  end

  // Output from the last divider stage
  assign m_tvalid = div_q[NumDivStages].valid;
  assign m_tdata  = {div_q[NumDivStages].bright,
                     div_q[NumDivStages].sat_low,
                     div_q[NumDivStages].hue_low};

  `B2H_ASSERT(a_hue_range, m_tvalid |-> (m_tdata[7:0] <= 8'd179), "hue out of range")
  `B2H_ASSERT(a_black_sat, (m_tvalid && m_tdata[23:16] == 8'd0) |-> (m_tdata[15:8] == 8'd0),
              "black pixel with nonzero saturation")
  `B2H_ASSERT(a_rst_empty, $past(rst) |-> !m_tvalid, "output valid right after reset")

endmodule
`default_nettype wire

### tb/sv/hsv_result_checker.sv
// Checker for the pixel converter: predicts HSV per request and compares each result.
`timescale 1ns / 1ps
module hsv_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // blue[7:0], green[15:8], red[23:16]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // hue_half_deg[7:0], saturation[15:8], brightness[23:16]
  output int          mismatches,
  output int          results_checked,
  output int          expected_left
);
  import b2h_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] brightness;
    logic [7:0] saturation;
    logic [7:0] hue_half_deg;
  } hsv_t;

  hsv_t expected_hsv[$];

  // Exact integer HSV of one pixel; ties for the maximum go red, then green
  function automatic hsv_t pixel_to_hsv(logic [7:0] blue, logic [7:0] green, logic [7:0] red);
    hsv_t res;
    sel_t top_chan;
    int   mx;
    int   mn;
    int   chroma;
    int   num;
    int   b;
    int   g;
    int   r;
    b = int'(blue);
    g = int'(green);
    r = int'(red);
    if (r >= g && r >= b) top_chan = SEL_RED;
    else if (g >= b) top_chan = SEL_GREEN;
    else top_chan = SEL_BLUE;
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    chroma = mx - mn;
    res.brightness = mx[7:0];
    res.saturation = (mx != 0) ? 8'((255 * chroma) / mx) : 8'd0;
    res.hue_half_deg = 8'd0;
    // grey pixel keeps hue 0
    if (chroma != 0) begin
      case (top_chan)
        SEL_RED:   num = 60 * (g - b);
        SEL_GREEN: num = 120 * chroma + 60 * (b - r);
        default:   num = 240 * chroma + 60 * (r - g);
      endcase
      if (num < 0) num += 360 * chroma;
      res.hue_half_deg = 8'(num / (2 * chroma));
    end
    return res;
  endfunction

  // Queue a prediction per request, compare per result
  always @(posedge clk) begin
    hsv_t want;
    hsv_t got;
    if (rst) begin
      mismatches = 0;
      results_checked = 0;
      expected_left = 0;
    end else begin
      if (s_tvalid && s_tready)
        expected_hsv.push_back(pixel_to_hsv(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]));
      if (m_tvalid && m_tready) begin
        got = hsv_t'(m_tdata);
        if (expected_hsv.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result hue=%0d sat=%0d val=%0d", $realtime,
                     got.hue_half_deg, got.saturation, got.brightness);
        end else begin
          want = expected_hsv.pop_front();
          results_checked++;
          if (got.hue_half_deg !== want.hue_half_deg || got.saturation !== want.saturation ||
              got.brightness !== want.brightness) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: result %0d expected hue=%0d sat=%0d val=%0d, %s%0d sat=%0d val=%0d",
                       $realtime, results_checked, want.hue_half_deg, want.saturation,
                       want.brightness, "got hue=", got.hue_half_deg, got.saturation,
                       got.brightness);
          end
        end
      end
      expected_left = expected_hsv.size();
    end
  end

endmodule

### tb/sv/tb_bgr_to_hsv_pixel_top.sv
// Testbench top: drives pixel requests and output stalls, gives the verdict.
`timescale 1ns / 1ps
module tb_bgr_to_hsv_pixel_top;

  localparam int RANDOM_PIXELS = 800;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_AFTER    = 300;
  localparam int IDLE_LIMIT    = 3000;
  localparam int DRAIN_CYCLES  = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = 24'd0;   // blue[7:0], green[15:8], red[23:16]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // hue_half_deg[7:0], saturation[15:8], brightness[23:16]

  int mismatches;
  int results_checked;
  int expected_left;
  int pixels_sent = 0;
  int idle_cycles = 0;
  bit long_hold_done = 1'b0;

  always #2 clk = ~clk;

  bgr_to_hsv_pixel_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  hsv_result_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .mismatches      (mismatches),
    .results_checked (results_checked),
    .expected_left   (expected_left)
  );

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // One request: optional idle gap, then hold valid until taken
  task automatic send_pixel(input logic [7:0] blue, input logic [7:0] green,
                            input logic [7:0] red, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {red, green, blue};
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
  endtask

  // Stimulus
  initial begin
    int burst_left;
    int kind;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] base;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: black, white, grey, primaries, ties, hue wrap, tiny chroma
    send_pixel(8'd0,   8'd0,   8'd0,   0);
    send_pixel(8'd255, 8'd255, 8'd255, 0);
    send_pixel(8'd128, 8'd128, 8'd128, 1);
    send_pixel(8'd0,   8'd0,   8'd255, 0);
    send_pixel(8'd0,   8'd255, 8'd0,   0);
    send_pixel(8'd255, 8'd0,   8'd0,   2);
    send_pixel(8'd1,   8'd0,   8'd255, 0);
    send_pixel(8'd200, 8'd10,  8'd201, 0);
    send_pixel(8'd0,   8'd255, 8'd255, 0);
    send_pixel(8'd255, 8'd255, 8'd0,   0);
    send_pixel(8'd255, 8'd0,   8'd255, 3);
    send_pixel(8'd50,  8'd100, 8'd100, 0);
    send_pixel(8'd100, 8'd100, 8'd50,  0);
    send_pixel(8'd100, 8'd50,  8'd100, 0);
    send_pixel(8'd0,   8'd0,   8'd1,   0);
    send_pixel(8'd1,   8'd0,   8'd0,   0);
    send_pixel(8'd0,   8'd1,   8'd0,   0);
    send_pixel(8'd254, 8'd255, 8'd254, 0);
    send_pixel(8'd255, 8'd1,   8'd0,   0);
    send_pixel(8'd0,   8'd255, 8'd1,   0);
    send_pixel(8'd170, 8'd85,  8'd0,   0);
    send_pixel(8'd1,   8'd1,   8'd1,   0);

    // random pixels, biased toward ties, greys and small chroma
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      kind = $urandom_range(0, 9);
      b = 8'($urandom);
      g = 8'($urandom);
      r = 8'($urandom);
      case (kind)
        5: begin
          case ($urandom_range(0, 2))
            0: g = r;
            1: b = g;
            default: b = r;
          endcase
        end
        6: begin
          g = b;
          r = b;
        end
        7: begin
          base = 8'($urandom_range(0, 252));
          b = base + 8'($urandom_range(0, 3));
          g = base + 8'($urandom_range(0, 3));
          r = base + 8'($urandom_range(0, 3));
        end
        8: begin
          b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          g = $urandom_range(0, 1) ? 8'd255 : g;
          r = $urandom_range(0, 1) ? 8'd0 : r;
        end
        9: begin
          case ($urandom_range(0, 2))
            0: r = 8'd255;
            1: g = 8'd255;
            default: b = 8'd255;
          endcase
        end
        default: ;
      endcase
      if (burst_left == 0 && $urandom_range(0, 99) == 0) burst_left = $urandom_range(30, 80);
      if (burst_left > 0) begin
        burst_left--;
        send_pixel(b, g, r, 0);
      end else begin
        send_pixel(b, g, r, pick_gap());
      end
    end
    s_tvalid <= 1'b0;

    // drain, then a short tail for stray results
    wait (results_checked == pixels_sent);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_left == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Output side: random ready/stall stretches plus one long hold-off
  initial begin
    int burst_left;
    int span;
    burst_left = 0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!long_hold_done && pixels_sent >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (burst_left > 0) begin
        span = $urandom_range(5, 20);
        burst_left = (burst_left > span) ? burst_left - span : 0;
        m_tready <= 1'b1;
        repeat (span) @(posedge clk);
      end else if ($urandom_range(0, 49) == 0) begin
        burst_left = $urandom_range(40, 120);
      end else if ($urandom_range(0, 1) == 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        span = pick_gap();
        m_tready <= 1'b0;
        repeat (span + 1) @(posedge clk);
      end
    end
  end

  // Watchdog: too long with no request or result moving
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
